FILE: hw/rtl/pwf_pkg.sv
// Types and constants shared by the wall-following steering controller.
package pwf_pkg;

  localparam int THR_W      = 12;
  localparam int GAIN_W     = 8;
  localparam int SPEED_W    = 10;
  localparam int EFFORT_W   = 12;
  localparam int INTEG_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int BIAS_W = 18;
  localparam logic [BIAS_W-1:0] BIAS_NUM = 18'd256000;

  localparam int IMAG_OFFSET = 240;
  localparam int EFFORT_MAX  = 1600;

  // Wheel speed is product / 3200, taken as (product >> 7) / 25 by a reciprocal.
  localparam int SPD_PRE_SHIFT = 7;
  localparam int SPD_DIV       = 25;
  localparam int RECIP_W       = 13;
  localparam int RECIP_SHIFT   = 17;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 13'd5243;

  localparam logic [THR_W-1:0]   RST_FRONT_THR = 12'd368;
  localparam logic [THR_W-1:0]   RST_BACK_THR  = 12'd368;
  localparam logic [THR_W-1:0]   RST_RIGHT_THR = 12'd320;
  localparam logic [THR_W-1:0]   RST_LEFT_THR  = 12'd320;
  localparam logic [GAIN_W-1:0]  RST_GAIN_P    = 8'd32;
  localparam logic [GAIN_W-1:0]  RST_GAIN_I    = 8'd0;
  localparam logic [GAIN_W-1:0]  RST_GAIN_D    = 8'd8;
  localparam logic [SPEED_W-1:0] RST_TOP_SPEED = 10'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_THR = 3'd0,
    REG_BACK_THR  = 3'd1,
    REG_RIGHT_THR = 3'd2,
    REG_LEFT_THR  = 3'd3,
    REG_GAIN_P    = 3'd4,
    REG_GAIN_I    = 3'd5,
    REG_GAIN_D    = 3'd6,
    REG_TOP_SPEED = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [THR_W-1:0]   front_thr;
    logic [THR_W-1:0]   back_thr;
    logic [THR_W-1:0]   right_thr;
    logic [THR_W-1:0]   left_thr;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SPEED_W-1:0] top_speed;
  } cfg_t;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_D = 2'd1,
    MUL_I = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    logic     err_en;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_clr;
    logic     acc_en;
    logic     eff_en;
    logic     spd_mul_en;
    logic     spd_rcp_en;
    logic     spd_fix_en;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

FILE: hw/rtl/pwf_if.sv
// Channel interfaces: range word input, steering word output and register writes.
interface pwf_in_if #(
  parameter int DIST_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] front_range;
  logic [DIST_BITS-1:0] back_range;
  logic [DIST_BITS-1:0] right_range;
  logic [DIST_BITS-1:0] left_range;
  logic                 clear_integral;

  modport source (
    output valid, front_range, back_range, right_range, left_range, clear_integral,
    input  ready
  );
  modport sink (
    input  valid, front_range, back_range, right_range, left_range, clear_integral,
    output ready
  );
endinterface

interface pwf_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  wall_found;
  logic signed [pwf_pkg::EFFORT_W-1:0]   steer_effort;
  logic        [pwf_pkg::SPEED_W-1:0]    left_speed;
  logic        [pwf_pkg::SPEED_W-1:0]    right_speed;

  modport source (
    output valid, wall_found, steer_effort, left_speed, right_speed,
    input  ready
  );
  modport sink (
    input  valid, wall_found, steer_effort, left_speed, right_speed,
    output ready
  );
endinterface

interface pwf_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pwf_pkg::CFG_IDX_W-1:0]     index;
  logic [pwf_pkg::CFG_DATA_W-1:0]    data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

FILE: hw/rtl/pwf_cfg_regs.sv
// Configuration register file: thresholds, gains and top speed.
module pwf_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [pwf_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [pwf_pkg::CFG_DATA_W-1:0] data_i,
  output pwf_pkg::cfg_t                  cfg_o
);

  pwf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_thr <= pwf_pkg::RST_FRONT_THR;
      cfg_q.back_thr  <= pwf_pkg::RST_BACK_THR;
      cfg_q.right_thr <= pwf_pkg::RST_RIGHT_THR;
      cfg_q.left_thr  <= pwf_pkg::RST_LEFT_THR;
      cfg_q.gain_p    <= pwf_pkg::RST_GAIN_P;
      cfg_q.gain_i    <= pwf_pkg::RST_GAIN_I;
      cfg_q.gain_d    <= pwf_pkg::RST_GAIN_D;
      cfg_q.top_speed <= pwf_pkg::RST_TOP_SPEED;
    end else if (wr_en_i) begin
      case (pwf_pkg::cfg_reg_e'(idx_i))
        pwf_pkg::REG_FRONT_THR: cfg_q.front_thr <= data_i[pwf_pkg::THR_W-1:0];
        pwf_pkg::REG_BACK_THR:  cfg_q.back_thr  <= data_i[pwf_pkg::THR_W-1:0];
        pwf_pkg::REG_RIGHT_THR: cfg_q.right_thr <= data_i[pwf_pkg::THR_W-1:0];
        pwf_pkg::REG_LEFT_THR:  cfg_q.left_thr  <= data_i[pwf_pkg::THR_W-1:0];
        pwf_pkg::REG_GAIN_P:    cfg_q.gain_p    <= data_i[pwf_pkg::GAIN_W-1:0];
        pwf_pkg::REG_GAIN_I:    cfg_q.gain_i    <= data_i[pwf_pkg::GAIN_W-1:0];
        pwf_pkg::REG_GAIN_D:    cfg_q.gain_d    <= data_i[pwf_pkg::GAIN_W-1:0];
        pwf_pkg::REG_TOP_SPEED: cfg_q.top_speed <= data_i[pwf_pkg::SPEED_W-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/pwf_div.sv
// Restoring divider that forms the front wall bias, one quotient bit per cycle.
module pwf_div #(
  parameter int DVS_W = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DVS_W-1:0]             divisor_i,
  output logic                         done_o,
  output logic [pwf_pkg::BIAS_W-1:0]   quot_o
);

  localparam int QW    = pwf_pkg::BIAS_W;
  localparam int CNT_W = $clog2(QW);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [QW-1:0]    quot_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W-1:0] dvs_q;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] rem_nx;
  logic           ge;

  always_comb begin
    rem_sh = {rem_q, quot_q[QW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= pwf_pkg::BIAS_NUM;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[QW-2:0], ge};
      rem_q  <= rem_nx[DVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: hw/rtl/pwf_datapath.sv
// Datapath: wall detection, error, PID accumulation and wheel speed arithmetic.
module pwf_datapath #(
  parameter int DIST_BITS  = 12,
  parameter int ERROR_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pwf_pkg::cfg_t                        cfg_i,
  input  pwf_pkg::cmd_t                        cmd_i,
  output pwf_pkg::status_t                     status_o,
  input  logic [DIST_BITS-1:0]                 front_i,
  input  logic [DIST_BITS-1:0]                 back_i,
  input  logic [DIST_BITS-1:0]                 right_i,
  input  logic [DIST_BITS-1:0]                 left_i,
  input  logic                                 clear_i,
  output logic                                 wall_found_o,
  output logic signed [pwf_pkg::EFFORT_W-1:0]  steer_effort_o,
  output logic [pwf_pkg::SPEED_W-1:0]          left_speed_o,
  output logic [pwf_pkg::SPEED_W-1:0]          right_speed_o
);

  localparam int THR_W    = pwf_pkg::THR_W;
  localparam int BIAS_W   = pwf_pkg::BIAS_W;
  localparam int GAIN_W   = pwf_pkg::GAIN_W;
  localparam int INTEG_W  = pwf_pkg::INTEG_W;
  localparam int EFFORT_W = pwf_pkg::EFFORT_W;
  localparam int SPEED_W  = pwf_pkg::SPEED_W;
  localparam int CMP_W    = (DIST_BITS > THR_W) ? DIST_BITS : THR_W;
  localparam int SIDE_W   = CMP_W + 1;
  localparam int SUM_W    = ((CMP_W + 1 > BIAS_W) ? CMP_W + 1 : BIAS_W) + 2;
  localparam int CL_W     = (SUM_W > ERROR_BITS) ? SUM_W : ERROR_BITS;
  localparam int DIFF_W   = ERROR_BITS + 1;
  localparam int MB_W     = (DIFF_W > INTEG_W) ? DIFF_W : INTEG_W;
  localparam int PROD_W   = MB_W + GAIN_W + 1;
  localparam int ACC_W    = PROD_W + 2;
  localparam int IS_W     = INTEG_W + 2;
  localparam int SP_W     = SPEED_W + EFFORT_W;
  localparam int Y_W      = SP_W - pwf_pkg::SPD_PRE_SHIFT;
  localparam int T_W      = Y_W + pwf_pkg::RECIP_W;
  localparam int Q_W      = T_W - pwf_pkg::RECIP_SHIFT;
  localparam int CHK_W    = Q_W + 5;

  localparam logic signed [CL_W-1:0]  ERR_MAX = CL_W'((64'sd1 <<< (ERROR_BITS - 1)) - 64'sd1);
  localparam logic signed [CL_W-1:0]  ERR_MIN = ~ERR_MAX;
  localparam logic signed [IS_W-1:0]  INT_MAX = IS_W'((64'sd1 <<< (INTEG_W - 1)) - 64'sd1);
  localparam logic signed [IS_W-1:0]  INT_MIN = ~INT_MAX;
  localparam logic signed [ACC_W-1:0] EFF_HI  = ACC_W'(pwf_pkg::EFFORT_MAX);
  localparam logic signed [ACC_W-1:0] EFF_LO  = ACC_W'(-pwf_pkg::EFFORT_MAX);

  logic [DIST_BITS-1:0] f_q, b_q, r_q, l_q;
  logic                 clr_q;

  logic signed [ERROR_BITS-1:0] err_q;
  logic signed [ERROR_BITS-1:0] prev_q;
  logic signed [DIFF_W-1:0]     diff_q;
  logic signed [INTEG_W-1:0]    integral_q;
  logic signed [INTEG_W-1:0]    integ_new_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic signed [ACC_W-1:0]      acc_q;
  logic signed [EFFORT_W-1:0]   effort_q;
  logic [SP_W-1:0]              pl_q, pr_q;
  logic [Y_W-1:0]               yl_q, yr_q;
  logic [T_W-1:0]               tl_q, tr_q;
  logic [SPEED_W-1:0]           sl_q, sr_q;

  logic                         found_q;
  logic signed [EFFORT_W-1:0]   out_eff_q;
  logic [SPEED_W-1:0]           out_l_q, out_r_q;

  logic [BIAS_W-1:0]    bias;
  logic [DIST_BITS-1:0] divisor;

  // Wall detection and side substitution.
  logic [CMP_W-1:0]         f_x, b_x, r_x, l_x;
  logic [CMP_W-1:0]         ft_x, bt_x, rt_x, lt_x;
  logic                     front_near, found, r_gt, l_gt;
  logic signed [SIDE_W-1:0] r_side, l_side;
  logic signed [SUM_W-1:0]  side_diff, err_raw;
  logic signed [CL_W-1:0]   err_ext, err_sat;

  always_comb begin
    f_x  = CMP_W'(f_q);
    b_x  = CMP_W'(b_q);
    r_x  = CMP_W'(r_q);
    l_x  = CMP_W'(l_q);
    ft_x = CMP_W'(cfg_i.front_thr);
    bt_x = CMP_W'(cfg_i.back_thr);
    rt_x = CMP_W'(cfg_i.right_thr);
    lt_x = CMP_W'(cfg_i.left_thr);
    front_near = f_x < ft_x;
    found      = front_near || (b_x < bt_x) || (r_x < rt_x) || (l_x < lt_x);
    r_gt = r_x > rt_x;
    l_gt = l_x > lt_x;
    r_side = r_gt ? SIDE_W'(SIDE_W'(rt_x) - SIDE_W'(pwf_pkg::IMAG_OFFSET)) : SIDE_W'(r_x);
    l_side = l_gt ? SIDE_W'(SIDE_W'(lt_x) - SIDE_W'(pwf_pkg::IMAG_OFFSET)) : SIDE_W'(l_x);
    side_diff = SUM_W'(r_side) - SUM_W'(l_side);
    if (!front_near) begin
      err_raw = side_diff;
    end else if (l_gt) begin
      err_raw = side_diff - SUM_W'(bias);
    end else begin
      err_raw = side_diff + SUM_W'(bias);
    end
    err_ext = CL_W'(err_raw);
    if (err_ext > ERR_MAX) begin
      err_sat = ERR_MAX;
    end else if (err_ext < ERR_MIN) begin
      err_sat = ERR_MIN;
    end else begin
      err_sat = err_ext;
    end
  end

  assign divisor = (f_q == '0) ? DIST_BITS'(1) : f_q;

  pwf_div #(
    .DVS_W (DIST_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .divisor_i (divisor),
    .done_o    (status_o.div_done),
    .quot_o    (bias)
  );

  // Integrator update and error difference.
  logic signed [IS_W-1:0] integ_base, integ_sum, integ_sat;

  always_comb begin
    integ_base = clr_q ? '0 : IS_W'(integral_q);
    integ_sum  = integ_base + IS_W'(err_q);
    if (integ_sum > INT_MAX) begin
      integ_sat = INT_MAX;
    end else if (integ_sum < INT_MIN) begin
      integ_sat = INT_MIN;
    end else begin
      integ_sat = integ_sum;
    end
  end

  // Shared gain multiplier.
  logic signed [GAIN_W:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_d;

  always_comb begin
    case (cmd_i.mul_sel)
      pwf_pkg::MUL_P: begin
        mul_a = {1'b0, cfg_i.gain_p};
        mul_b = MB_W'(err_q);
      end
      pwf_pkg::MUL_D: begin
        mul_a = {1'b0, cfg_i.gain_d};
        mul_b = MB_W'(diff_q);
      end
      pwf_pkg::MUL_I: begin
        mul_a = {1'b0, cfg_i.gain_i};
        mul_b = MB_W'(integ_new_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Effort clamp and wheel speed terms.
  logic signed [ACC_W-1:0]    raw16;
  logic signed [EFFORT_W-1:0] eff_d;
  logic signed [EFFORT_W:0]   sum_l, sum_r;
  logic [Q_W-1:0]             ql, qr;
  logic [CHK_W-1:0]           chk_l, chk_r;

  always_comb begin
    raw16 = acc_q >>> 4;
    if (raw16 > EFF_HI) begin
      eff_d = EFFORT_W'(EFF_HI);
    end else if (raw16 < EFF_LO) begin
      eff_d = EFFORT_W'(EFF_LO);
    end else begin
      eff_d = EFFORT_W'(raw16);
    end
    sum_l = (EFFORT_W + 1)'(pwf_pkg::EFFORT_MAX) + (EFFORT_W + 1)'(effort_q);
    sum_r = (EFFORT_W + 1)'(pwf_pkg::EFFORT_MAX) - (EFFORT_W + 1)'(effort_q);
    ql    = tl_q[T_W-1:pwf_pkg::RECIP_SHIFT];
    qr    = tr_q[T_W-1:pwf_pkg::RECIP_SHIFT];
    chk_l = CHK_W'(ql) * CHK_W'(pwf_pkg::SPD_DIV);
    chk_r = CHK_W'(qr) * CHK_W'(pwf_pkg::SPD_DIV);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= '0;
      prev_q     <= '0;
    end else if (cmd_i.commit && found) begin
      integral_q <= integ_new_q;
      prev_q     <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      f_q   <= front_i;
      b_q   <= back_i;
      r_q   <= right_i;
      l_q   <= left_i;
      clr_q <= clear_i;
    end
    if (cmd_i.err_en) begin
      err_q <= ERROR_BITS'(err_sat);
    end
    if (cmd_i.acc_clr) begin
      integ_new_q <= INTEG_W'(integ_sat);
      diff_q      <= DIFF_W'(err_q) - DIFF_W'(prev_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.eff_en) begin
      effort_q <= eff_d;
    end
    if (cmd_i.spd_mul_en) begin
      pl_q <= SP_W'(cfg_i.top_speed) * SP_W'(sum_l[EFFORT_W-1:0]);
      pr_q <= SP_W'(cfg_i.top_speed) * SP_W'(sum_r[EFFORT_W-1:0]);
    end
    if (cmd_i.spd_rcp_en) begin
      yl_q <= pl_q[SP_W-1:pwf_pkg::SPD_PRE_SHIFT];
      yr_q <= pr_q[SP_W-1:pwf_pkg::SPD_PRE_SHIFT];
      tl_q <= T_W'(pl_q[SP_W-1:pwf_pkg::SPD_PRE_SHIFT]) * T_W'(pwf_pkg::RECIP_MUL);
      tr_q <= T_W'(pr_q[SP_W-1:pwf_pkg::SPD_PRE_SHIFT]) * T_W'(pwf_pkg::RECIP_MUL);
    end
    if (cmd_i.spd_fix_en) begin
      sl_q <= (chk_l > CHK_W'(yl_q)) ? SPEED_W'(ql - Q_W'(1)) : SPEED_W'(ql);
      sr_q <= (chk_r > CHK_W'(yr_q)) ? SPEED_W'(qr - Q_W'(1)) : SPEED_W'(qr);
    end
    if (cmd_i.commit) begin
      found_q   <= found;
      out_eff_q <= found ? effort_q : '0;
      out_l_q   <= found ? sl_q : '0;
      out_r_q   <= found ? sr_q : '0;
    end
  end

  assign wall_found_o   = found_q;
  assign steer_effort_o = out_eff_q;
  assign left_speed_o   = out_l_q;
  assign right_speed_o  = out_r_q;

endmodule

FILE: hw/rtl/pwf_ctrl.sv
// Sequencer that steps the datapath through one steering word and owns the handshakes.
module pwf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  pwf_pkg::status_t  status_i,
  output pwf_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_ERR,
    S_MUL_P,
    S_MUL_D,
    S_MUL_I,
    S_ACC,
    S_EFF,
    S_SPD_MUL,
    S_SPD_RCP,
    S_SPD_FIX,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   can_commit;

  assign can_commit = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && can_commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE:     if (in_valid_i) state_q <= S_DIV_GO;
        S_DIV_GO:   state_q <= S_DIV_WAIT;
        S_DIV_WAIT: if (status_i.div_done) state_q <= S_ERR;
        S_ERR:      state_q <= S_MUL_P;
        S_MUL_P:    state_q <= S_MUL_D;
        S_MUL_D:    state_q <= S_MUL_I;
        S_MUL_I:    state_q <= S_ACC;
        S_ACC:      state_q <= S_EFF;
        S_EFF:      state_q <= S_SPD_MUL;
        S_SPD_MUL:  state_q <= S_SPD_RCP;
        S_SPD_RCP:  state_q <= S_SPD_FIX;
        S_SPD_FIX:  state_q <= S_DONE;
        S_DONE:     if (can_commit) state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.mul_sel    = pwf_pkg::MUL_P;
    cmd_o.load       = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_start  = state_q == S_DIV_GO;
    cmd_o.err_en     = state_q == S_ERR;
    cmd_o.eff_en     = state_q == S_EFF;
    cmd_o.spd_mul_en = state_q == S_SPD_MUL;
    cmd_o.spd_rcp_en = state_q == S_SPD_RCP;
    cmd_o.spd_fix_en = state_q == S_SPD_FIX;
    cmd_o.commit     = (state_q == S_DONE) && can_commit;
    case (state_q)
      S_MUL_P: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.acc_clr = 1'b1;
      end
      S_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pwf_pkg::MUL_D;
        cmd_o.acc_en  = 1'b1;
      end
      S_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pwf_pkg::MUL_I;
        cmd_o.acc_en  = 1'b1;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
      end
      default: begin
        cmd_o.mul_en = 1'b0;
      end
    endcase
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/pid_wall_follow_steering_core.sv
// A new range word is taken only when the sequencer is idle; each word passes
// through the bias divider and the single shared gain multiplier, and a stalled
// output holds the sequencer before it commits.
// The result waits in an output register, so a new word is taken while it waits.
// Reset is asynchronous and active low: registers return to their defaults, the
// integrator and the previous error clear to zero, and both channels go idle.
module pid_wall_follow_steering_core #(
  parameter int DIST_BITS  = 12,
  parameter int ERROR_BITS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pwf_cfg_if.sink   cfg_i,
  pwf_in_if.sink    in_i,
  pwf_out_if.source out_o
);

  pwf_pkg::cfg_t    cfg;
  pwf_pkg::cmd_t    cmd;
  pwf_pkg::status_t status;
  logic             in_ready;
  logic             out_valid;

  assign cfg_i.ready = 1'b1;

  pwf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid),
    .idx_i   (cfg_i.index),
    .data_i  (cfg_i.data),
    .cfg_o   (cfg)
  );

  pwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pwf_datapath #(
    .DIST_BITS  (DIST_BITS),
    .ERROR_BITS (ERROR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .front_i        (in_i.front_range),
    .back_i         (in_i.back_range),
    .right_i        (in_i.right_range),
    .left_i         (in_i.left_range),
    .clear_i        (in_i.clear_integral),
    .wall_found_o   (out_o.wall_found),
    .steer_effort_o (out_o.steer_effort),
    .left_speed_o   (out_o.left_speed),
    .right_speed_o  (out_o.right_speed)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

FILE: dv/tb_pid_wall_follow_steering_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the wall-following steering core, with a PID predictor.
module tb_pid_wall_follow_steering_core;

  localparam int DIST_W = 12;
  localparam int ERROR_BITS = 24;
  localparam int HANG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 212;
  localparam longint ERR_TOP = (64'sd1 <<< (ERROR_BITS - 1)) - 1;
  localparam longint INTEG_TOP = 64'sd2147483647;

  typedef struct {
    logic [DIST_W-1:0] front;
    logic [DIST_W-1:0] back;
    logic [DIST_W-1:0] right;
    logic [DIST_W-1:0] left;
    logic              clear;
  } range_word_t;

  typedef struct {
    logic                                wall_found;
    logic signed [pwf_pkg::EFFORT_W-1:0] effort;
    logic [pwf_pkg::SPEED_W-1:0]         left_speed;
    logic [pwf_pkg::SPEED_W-1:0]         right_speed;
  } steer_word_t;

  class steering_scoreboard;
    steer_word_t expected_q[$];
    int front_thr, back_thr, right_thr, left_thr;
    int gain_p, gain_i, gain_d, top_speed;
    longint integ_sum, last_error;
    int mismatches;

    function new();
      front_thr = pwf_pkg::RST_FRONT_THR;
      back_thr = pwf_pkg::RST_BACK_THR;
      right_thr = pwf_pkg::RST_RIGHT_THR;
      left_thr = pwf_pkg::RST_LEFT_THR;
      gain_p = pwf_pkg::RST_GAIN_P;
      gain_i = pwf_pkg::RST_GAIN_I;
      gain_d = pwf_pkg::RST_GAIN_D;
      top_speed = pwf_pkg::RST_TOP_SPEED;
      integ_sum = 0;
      last_error = 0;
      mismatches = 0;
    endfunction

    function void set_register(pwf_pkg::cfg_reg_e idx,
                               logic [pwf_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        pwf_pkg::REG_FRONT_THR: front_thr = data[pwf_pkg::THR_W-1:0];
        pwf_pkg::REG_BACK_THR:  back_thr = data[pwf_pkg::THR_W-1:0];
        pwf_pkg::REG_RIGHT_THR: right_thr = data[pwf_pkg::THR_W-1:0];
        pwf_pkg::REG_LEFT_THR:  left_thr = data[pwf_pkg::THR_W-1:0];
        pwf_pkg::REG_GAIN_P:    gain_p = data[pwf_pkg::GAIN_W-1:0];
        pwf_pkg::REG_GAIN_I:    gain_i = data[pwf_pkg::GAIN_W-1:0];
        pwf_pkg::REG_GAIN_D:    gain_d = data[pwf_pkg::GAIN_W-1:0];
        pwf_pkg::REG_TOP_SPEED: top_speed = data[pwf_pkg::SPEED_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void note_range_word(range_word_t w);
      longint f, b, r, l, err, bias, raw, eff;
      bit left_imag, front_near;
      steer_word_t res;
      f = w.front;
      b = w.back;
      r = w.right;
      l = w.left;
      left_imag = 1'b0;
      front_near = f < front_thr;
      res.wall_found = 1'b0;
      res.effort = '0;
      res.left_speed = '0;
      res.right_speed = '0;
      if (!(front_near || b < back_thr || r < right_thr || l < left_thr)) begin
        expected_q.push_back(res);
        return;
      end
      // A missing side wall is replaced by an imaginary one, which may lie below zero.
      if (r > right_thr) r = right_thr - pwf_pkg::IMAG_OFFSET;
      if (l > left_thr) begin
        l = left_thr - pwf_pkg::IMAG_OFFSET;
        left_imag = 1'b1;
      end
      err = r - l;
      if (front_near) begin
        bias = longint'(pwf_pkg::BIAS_NUM) / ((f == 0) ? 1 : f);
        err = left_imag ? err - bias : err + bias;
      end
      err = clip(err, -ERR_TOP - 1, ERR_TOP);
      if (w.clear) integ_sum = 0;
      integ_sum = clip(integ_sum + err, -INTEG_TOP - 1, INTEG_TOP);
      raw = gain_p * err + gain_d * (err - last_error) + gain_i * integ_sum;
      eff = clip(raw >>> 4, -pwf_pkg::EFFORT_MAX, pwf_pkg::EFFORT_MAX);
      last_error = err;
      res.wall_found = 1'b1;
      res.effort = eff[pwf_pkg::EFFORT_W-1:0];
      res.left_speed = pwf_pkg::SPEED_W'((top_speed * (pwf_pkg::EFFORT_MAX + eff)) /
                                         (2 * pwf_pkg::EFFORT_MAX));
      res.right_speed = pwf_pkg::SPEED_W'((top_speed * (pwf_pkg::EFFORT_MAX - eff)) /
                                          (2 * pwf_pkg::EFFORT_MAX));
      expected_q.push_back(res);
    endfunction

    function void check_steering_word(steer_word_t got);
      steer_word_t want;
      if (expected_q.size() == 0) begin
        $error("steering word with no expectation waiting");
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (got.wall_found !== want.wall_found) begin
        $error("wall_found: expected %0d, got %0d", want.wall_found, got.wall_found);
        mismatches++;
      end
      if (got.effort !== want.effort) begin
        $error("steer_effort: expected %0d, got %0d", want.effort, got.effort);
        mismatches++;
      end
      if (got.left_speed !== want.left_speed) begin
        $error("left_speed: expected %0d, got %0d", want.left_speed, got.left_speed);
        mismatches++;
      end
      if (got.right_speed !== want.right_speed) begin
        $error("right_speed: expected %0d, got %0d", want.right_speed, got.right_speed);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_request = 0;
  int idle_cycles = 0;
  range_word_t seen_range;
  steer_word_t seen_steer;
  steering_scoreboard steer_sb = new();

  pwf_in_if #(.DIST_BITS(DIST_W)) in_ch ();
  pwf_out_if out_ch ();
  pwf_cfg_if cfg_ch ();

  pid_wall_follow_steering_core #(
    .DIST_BITS (DIST_W),
    .ERROR_BITS(ERROR_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      seen_range.front = in_ch.front_range;
      seen_range.back = in_ch.back_range;
      seen_range.right = in_ch.right_range;
      seen_range.left = in_ch.left_range;
      seen_range.clear = in_ch.clear_integral;
      steer_sb.note_range_word(seen_range);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen_steer.wall_found = out_ch.wall_found;
      seen_steer.effort = out_ch.steer_effort;
      seen_steer.left_speed = out_ch.left_speed;
      seen_steer.right_speed = out_ch.right_speed;
      steer_sb.check_steering_word(seen_steer);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_ch.valid && cfg_ch.ready)
      steer_sb.set_register(pwf_pkg::cfg_reg_e'(cfg_ch.index), cfg_ch.data);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // The long hold-off is counted here, so the sender keeps offering words meanwhile.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_range(input logic [DIST_W-1:0] f, b, r, l, input logic clr);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.front_range <= f;
    in_ch.back_range <= b;
    in_ch.right_range <= r;
    in_ch.left_range <= l;
    in_ch.clear_integral <= clr;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic logic [DIST_W-1:0] pick_range(int thr);
    int near_v;
    case ($urandom_range(9))
      0, 1: return DIST_W'($urandom_range(4095));
      2: return $urandom_range(1) ? 12'd0 : 12'd4095;
      3, 4, 5: return (thr == 0) ? 12'd0 : DIST_W'($urandom_range(thr - 1));
      6: begin
        near_v = thr + int'($urandom_range(6)) - 3;
        if (near_v < 0) near_v = 0;
        if (near_v > 4095) near_v = 4095;
        return DIST_W'(near_v);
      end
      default: return (thr >= 4095) ? 12'd4095 : DIST_W'($urandom_range(4095, thr + 1));
    endcase
  endfunction

  task automatic send_random_range();
    send_range(pick_range(steer_sb.front_thr), pick_range(steer_sb.back_thr),
               pick_range(steer_sb.right_thr), pick_range(steer_sb.left_thr),
               $urandom_range(7) == 0);
  endtask

  task automatic cfg_write(input pwf_pkg::cfg_reg_e idx,
                           input logic [pwf_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Unused upper data bits of the narrower registers carry noise.
  task automatic load_settings(input logic [pwf_pkg::THR_W-1:0] ft, bt, rt, lt,
                               input logic [pwf_pkg::GAIN_W-1:0] gp, gi, gd,
                               input logic [pwf_pkg::SPEED_W-1:0] ts);
    cfg_write(pwf_pkg::REG_FRONT_THR, ft);
    cfg_write(pwf_pkg::REG_BACK_THR, bt);
    cfg_write(pwf_pkg::REG_RIGHT_THR, rt);
    cfg_write(pwf_pkg::REG_LEFT_THR, lt);
    cfg_write(pwf_pkg::REG_GAIN_P, {4'($urandom), gp});
    cfg_write(pwf_pkg::REG_GAIN_I, {4'($urandom), gi});
    cfg_write(pwf_pkg::REG_GAIN_D, {4'($urandom), gd});
    cfg_write(pwf_pkg::REG_TOP_SPEED, {2'($urandom), ts});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    while (steer_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [pwf_pkg::THR_W-1:0] pick_threshold();
    return $urandom_range(1) ? pwf_pkg::THR_W'($urandom_range(4095))
                             : pwf_pkg::THR_W'($urandom_range(800, 160));
  endfunction

  task automatic set_idle_mode(input int phase);
    case (phase % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 82; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 82; end
      default: begin src_idle_pct = 28; sink_stall_pct = 28; end
    endcase
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.front_range = '0;
    in_ch.back_range = '0;
    in_ch.right_range = '0;
    in_ch.left_range = '0;
    in_ch.clear_integral = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = pwf_pkg::REG_FRONT_THR;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_range(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    send_range(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    send_range(12'd368, 12'd368, 12'd320, 12'd320, 1'b0);
    send_range(12'd0, 12'd0, 12'd0, 12'd0, 1'b0);
    send_range(12'd367, 12'd4095, 12'd320, 12'd320, 1'b0);
    send_range(12'd4095, 12'd0, 12'd4095, 12'd100, 1'b0);
    send_range(12'd100, 12'd4095, 12'd100, 12'd4095, 1'b0);
    send_range(12'd50, 12'd4095, 12'd4095, 12'd4095, 1'b0);
    send_range(12'd4095, 12'd4095, 12'd319, 12'd4095, 1'b1);
    send_range(12'd1, 12'd4095, 12'd200, 12'd300, 1'b0);
    send_range(12'd4095, 12'd4095, 12'd4095, 12'd319, 1'b0);
    send_range(12'd2000, 12'd100, 12'd150, 12'd160, 1'b0);
    send_range(12'd0, 12'd4095, 12'd4095, 12'd4095, 1'b1);
    send_range(12'd4095, 12'd367, 12'd321, 12'd321, 1'b0);
    send_range(12'd3000, 12'd2730, 12'd1365, 12'd2730, 1'b0);
    repeat (100) send_random_range();
    in_ch.valid <= 1'b0;

    for (int phase = 1; phase < 8; phase++) begin
      settle();
      case (phase)
        1: load_settings(12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255,
                         10'd1023);
        2: load_settings(12'd0, 12'd0, 12'd100, 12'd50, 8'd0, 8'd0, 8'd0, 10'd0);
        3: load_settings(12'd368, 12'd368, 12'd320, 12'd320, 8'd255, 8'd0, 8'd255,
                         10'd1023);
        default: load_settings(pick_threshold(), pick_threshold(), pick_threshold(),
                               pick_threshold(), pwf_pkg::GAIN_W'($urandom_range(255)),
                               ($urandom_range(3) == 0)
                                 ? pwf_pkg::GAIN_W'($urandom_range(255))
                                 : pwf_pkg::GAIN_W'($urandom_range(8)),
                               pwf_pkg::GAIN_W'($urandom_range(255)),
                               pwf_pkg::SPEED_W'($urandom_range(1023)));
      endcase
      set_idle_mode(phase);
      if (phase == 2) hold_request = HOLD_CYCLES;
      repeat (PHASE_WORDS) send_random_range();
      in_ch.valid <= 1'b0;
    end

    settle();
    if (steer_sb.mismatches == 0 && steer_sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
